[design/smrf_pkg.sv]
package smrf_pkg;

  // Default sizing
  localparam int DEF_FIFO_DEPTH = 16;
  localparam int DEF_ID_BYTES   = 7;

  // Command codes
  localparam logic [1:0] CMD_MOTION = 2'd0;
  localparam logic [1:0] CMD_MODEM  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Byte position inside a three-byte motion frame
  localparam logic [1:0] PH_HEAD = 2'd0;
  localparam logic [1:0] PH_X    = 2'd1;
  localparam logic [1:0] PH_Y    = 2'd2;

  // Modem line pattern with DTR and RTS both set
  localparam logic [1:0] LINES_BOTH = 2'b11;

  localparam logic [7:0] FRAME_SYNC = 8'h40;
  localparam logic [7:0] ID_CHAR    = 8'h4D;

  // One stored motion frame; the head byte is rebuilt on the way out
  typedef struct packed {
    logic       left;
    logic       right;
    logic [6:0] x;
    logic [6:0] y;
  } frame_t;

  // Result of one item, minus the level
  typedef struct packed {
    logic [7:0] read_data;
    logic       taken;
  } res_t;

  // Byte of a frame at the given position
  function automatic logic [7:0] frame_byte(input frame_t f, input logic [1:0] ph);
    logic [7:0] b;
    case (ph)
      PH_HEAD: b = FRAME_SYNC | {2'b00, f.left, f.right, f.y[6], f.y[6], f.x[6], f.x[6]};
      PH_X:    b = {2'b00, f.x[5:0]};
      PH_Y:    b = {2'b00, f.y[5:0]};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[design/smrf_frame_ram.sv]
module smrf_frame_ram #(
  parameter int Depth = 6,
  parameter int AddrW = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we,
  input  logic [AddrW-1:0]      waddr,
  input  smrf_pkg::frame_t      wdata,
  input  logic [AddrW-1:0]      raddr,
  output smrf_pkg::frame_t      rdata
);
  import smrf_pkg::*;

  frame_t mem [Depth];
  frame_t rd_q_r;
  frame_t wdata_r;
  logic   fwd_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, plus the frame written to the same entry in that cycle
  always_ff @(posedge clk) begin
    rd_q_r  <= mem[raddr];
    wdata_r <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= we && (waddr == raddr);
    end
  end

  assign rdata = fwd_r ? wdata_r : rd_q_r;

endmodule

[design/smrf_ctrl.sv]
module smrf_ctrl #(
  parameter int FIFO_DEPTH = smrf_pkg::DEF_FIFO_DEPTH,
  parameter int ID_BYTES   = smrf_pkg::DEF_ID_BYTES,
  parameter int FrameDepth = (FIFO_DEPTH + 2) / 3,
  parameter int AddrW      = $clog2(FrameDepth),
  parameter int CntW       = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [1:0]            cmd,
  input  logic signed [6:0]     x_move,
  input  logic signed [6:0]     y_move,
  input  logic [2:0]            button_bits,
  input  logic [1:0]            modem_lines,
  input  smrf_pkg::frame_t      head_frame,
  output logic                  ram_we,
  output logic [AddrW-1:0]      ram_waddr,
  output smrf_pkg::frame_t      ram_wdata,
  output logic [AddrW-1:0]      ram_raddr,
  output smrf_pkg::res_t        res,
  output logic [CntW-1:0]       level
);
  import smrf_pkg::*;

  localparam int IdN = (ID_BYTES < FIFO_DEPTH) ? ID_BYTES : FIFO_DEPTH;
  localparam int IdW = $clog2(IdN + 1);

  logic [AddrW-1:0] rp_r, rp_nxt;
  logic [AddrW-1:0] wp_r, wp_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic [IdW-1:0]   id_left_r, id_left_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [2:0]       last_btn_r, last_btn_nxt;
  logic [1:0]       last_lines_r, last_lines_nxt;
  logic             news;
  logic             room;

  function automatic logic [AddrW-1:0] ptr_inc(input logic [AddrW-1:0] p);
    return (p == AddrW'(FrameDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign news = (x_move != 7'sd0) || (y_move != 7'sd0) || (button_bits != last_btn_r);
  assign room = (count_r <= CntW'(FIFO_DEPTH - 3));

  assign ram_wdata = '{left:  button_bits[0],
                       right: button_bits[1],
                       x:     $unsigned(x_move),
                       y:     $unsigned(y_move)};
  assign ram_waddr = wp_r;
  assign ram_raddr = rp_nxt;

  // Decode the item and work out the next state
  always_comb begin
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    count_nxt      = count_r;
    id_left_nxt    = id_left_r;
    phase_nxt      = phase_r;
    last_btn_nxt   = last_btn_r;
    last_lines_nxt = last_lines_r;
    ram_we         = 1'b0;
    res            = '{read_data: 8'h00, taken: 1'b0};
    if (accept) begin
      case (cmd)
        CMD_MOTION: begin
          if (news && room) begin
            ram_we       = 1'b1;
            wp_nxt       = ptr_inc(wp_r);
            count_nxt    = count_r + CntW'(3);
            last_btn_nxt = button_bits;
            res.taken    = 1'b1;
          end
        end
        CMD_MODEM: begin
          // Joint rise of DTR and RTS: flush and queue the ID bytes
          if (modem_lines == LINES_BOTH && last_lines_r != LINES_BOTH) begin
            rp_nxt      = wp_r;
            count_nxt   = CntW'(IdN);
            id_left_nxt = IdW'(IdN);
            phase_nxt   = PH_HEAD;
          end
          last_lines_nxt = modem_lines;
        end
        CMD_READ: begin
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
            if (id_left_r != '0) begin
              res.read_data = ID_CHAR;
              id_left_nxt   = id_left_r - 1'b1;
            end else begin
              res.read_data = frame_byte(head_frame, phase_r);
              // Advance to the next frame after its last byte
              if (phase_r == PH_Y) begin
                phase_nxt = PH_HEAD;
                rp_nxt    = ptr_inc(rp_r);
              end else begin
                phase_nxt = phase_r + 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign level = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r         <= '0;
      wp_r         <= '0;
      count_r      <= '0;
      id_left_r    <= '0;
      phase_r      <= PH_HEAD;
      last_btn_r   <= '0;
      last_lines_r <= '0;
    end else begin
      rp_r         <= rp_nxt;
      wp_r         <= wp_nxt;
      count_r      <= count_nxt;
      id_left_r    <= id_left_nxt;
      phase_r      <= phase_nxt;
      last_btn_r   <= last_btn_nxt;
      last_lines_r <= last_lines_nxt;
    end
  end

endmodule

[design/serial_mouse_report_fifo.sv]
// Serial mouse transmit side with its receive byte queue. One command is
// taken every clock cycle and its result shows on the output register in the
// next cycle; the block keeps taking commands while a result waits, as long
// as out_ready frees the register. Motion frames are kept as one compact
// record per frame in a single-port-write, registered-read frame memory of
// ceil(FIFO_DEPTH/3) entries; the head record is prefetched every cycle and a
// write to the entry being prefetched is forwarded, so a read right after a
// report sees its bytes. Identification bytes are never stored: a counter
// serves them ahead of any frames. There is no clearing pass after reset.
module serial_mouse_report_fifo #(
  parameter int FIFO_DEPTH = smrf_pkg::DEF_FIFO_DEPTH,
  parameter int ID_BYTES   = smrf_pkg::DEF_ID_BYTES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_cmd,
  input  logic signed [6:0]                    in_x_move,
  input  logic signed [6:0]                    in_y_move,
  input  logic [2:0]                           in_button_bits,
  input  logic [1:0]                           in_modem_lines,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_read_data,
  output logic                                 out_has_data,
  output logic [$clog2(FIFO_DEPTH + 1)-1:0]    out_fifo_level,
  output logic                                 out_report_taken
);
  import smrf_pkg::*;

  localparam int FrameDepth = (FIFO_DEPTH + 2) / 3;
  localparam int AddrW      = $clog2(FrameDepth);
  localparam int CntW       = $clog2(FIFO_DEPTH + 1);

  logic             accept;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [AddrW-1:0] ram_raddr;
  frame_t           ram_wdata;
  frame_t           head_frame;
  res_t             res;
  logic [CntW-1:0]  level;

  logic             out_valid_r;
  logic [7:0]       read_data_r;
  logic [CntW-1:0]  level_r;
  logic             taken_r;

  // Take a new transfer whenever the output register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  smrf_ctrl #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .ID_BYTES   (ID_BYTES),
    .FrameDepth (FrameDepth),
    .AddrW      (AddrW),
    .CntW       (CntW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cmd         (in_cmd),
    .x_move      (in_x_move),
    .y_move      (in_y_move),
    .button_bits (in_button_bits),
    .modem_lines (in_modem_lines),
    .head_frame  (head_frame),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .res         (res),
    .level       (level)
  );

  smrf_frame_ram #(
    .Depth (FrameDepth),
    .AddrW (AddrW)
  ) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (head_frame)
  );

  // Hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data_r <= res.read_data;
      level_r     <= level;
      taken_r     <= res.taken;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = read_data_r;
  assign out_fifo_level   = level_r;
  assign out_has_data     = (level_r != '0);
  assign out_report_taken = taken_r;

endmodule

[design/smrf_checker.sv]
module smrf_checker #(
  parameter int FIFO_DEPTH = smrf_pkg::DEF_FIFO_DEPTH
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [7:0]                        out_read_data,
  input logic                              out_has_data,
  input logic [$clog2(FIFO_DEPTH + 1)-1:0] out_fifo_level,
  input logic                              out_report_taken
);

  // A result never sits stalled while its payload moves
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_fifo_level) && $stable(out_report_taken))
    else $error("stalled result changed");

  // Every accepted transfer shows a result in the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transfer gave no result");

  // A taken report never pops a byte at the same time and leaves data in the queue
  a_taken_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_report_taken |-> out_read_data == 8'h00 && out_has_data)
    else $error("report result carries read data");

  // Level stays within the queue and agrees with the data flag
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fifo_level <= ($clog2(FIFO_DEPTH + 1))'(FIFO_DEPTH)
      && out_has_data == (out_fifo_level != '0))
    else $error("queue level out of range");

endmodule

bind serial_mouse_report_fifo smrf_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_smrf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_read_data    (out_read_data),
  .out_has_data     (out_has_data),
  .out_fifo_level   (out_fifo_level),
  .out_report_taken (out_report_taken)
);
